// File: design/apsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsu_pkg
// shared types, constants and the sine table function of the partial synth
// ----------------------------------------------------------------------------
package apsu_pkg;

  localparam int MAX_PARTIALS_DEF    = 16;
  localparam int MAX_POINTS_DEF      = 16;
  localparam int SINE_INDEX_BITS_DEF = 10;

  // envelope value for 1.0 in q4.12
  localparam logic signed [15:0] ONE_Q12 = 16'sd4096;

  // quotient bits of the envelope divide (|v1 - v0| stays below 2^17)
  localparam int QUOT_W  = 17;
  localparam int QSTEP_W = $clog2(QUOT_W);

  // 2*pi in q30
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_PARTIAL = 3'd1,
    CMD_AMP     = 3'd2,
    CMD_PHASE   = 3'd3,
    CMD_SAMPLE  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ENV_IDLE,
    ENV_SCAN,
    ENV_EVAL,
    ENV_MUL,
    ENV_DIV,
    ENV_FIN,
    ENV_DONE
  } env_state_t;

  typedef enum logic [2:0] {
    OSC_IDLE,
    OSC_ADD,
    OSC_WRITE,
    OSC_RUN,
    OSC_DONE
  } osc_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_ENV,
    ST_OSC,
    ST_MLO,
    ST_MHI,
    ST_SCALE,
    ST_SAT,
    ST_OUT
  } top_state_t;

  // width of the signed sum of gain * sine over n partials
  function automatic int sum_width(input int n);
    return 32 + $clog2(n + 1);
  endfunction

  // quarter wave sine in q1.15, taylor series to x^13, elaborated as constants
  function automatic logic [14:0] quarter_sine(input int unsigned q,
                                               input int unsigned bits);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] acc;
    x    = (64'(q) * TWO_PI_Q30) >> bits;
    term = x;
    acc  = $signed(x);
    term = (term * x) >> 30;  term = (term * x) >> 30;  term = term / 6;
    acc  = acc - $signed(term);
    term = (term * x) >> 30;  term = (term * x) >> 30;  term = term / 20;
    acc  = acc + $signed(term);
    term = (term * x) >> 30;  term = (term * x) >> 30;  term = term / 42;
    acc  = acc - $signed(term);
    term = (term * x) >> 30;  term = (term * x) >> 30;  term = term / 72;
    acc  = acc + $signed(term);
    term = (term * x) >> 30;  term = (term * x) >> 30;  term = term / 110;
    acc  = acc - $signed(term);
    term = (term * x) >> 30;  term = (term * x) >> 30;  term = term / 156;
    acc  = acc + $signed(term);
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 64'sd16384) >>> 15;
    if (acc > 64'sd32767) begin
      acc = 64'sd32767;
    end
    return acc[14:0];
  endfunction

endpackage

// File: design/apsu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsu_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module apsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/apsu_env.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsu_env
// breakpoint store and piecewise linear envelope evaluation
// ----------------------------------------------------------------------------
module apsu_env #(
  parameter int MAX_POINTS = apsu_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               wr,
  input  logic [23:0]        wr_time,
  input  logic signed [15:0] wr_value,
  output logic               full,
  input  logic               start,
  input  logic [23:0]        t,
  output logic               done,
  output logic signed [15:0] value
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int QW = apsu_pkg::QUOT_W;

  apsu_pkg::env_state_t state, state_next;

  logic [CW-1:0]        count;
  logic [CW-1:0]        issue;
  logic                 rd_valid;
  logic [CW-1:0]        rd_pos;
  logic [39:0]          rdata;
  logic [23:0]          cur_t;
  logic signed [15:0]   cur_v;
  logic [23:0]          t_q;
  logic [23:0]          first_t, last_t, s_t0, s_t1;
  logic signed [15:0]   first_v, last_v, prev_v, s_v0, s_v1;
  logic [23:0]          prev_t;
  logic                 found;
  logic [23:0]          dt, den, rem;
  logic signed [16:0]   dv;
  logic                 neg;
  logic [QW-1:0]        quo;
  logic [apsu_pkg::QSTEP_W-1:0] qstep;
  logic                 early;
  logic signed [41:0]   prod;
  logic [41:0]          mag;
  logic [24:0]          sh;
  logic                 qbit;
  logic signed [17:0]   fin_sum;
  logic signed [17:0]   qs;

  assign full  = (count == CW'(MAX_POINTS));
  assign cur_t = rdata[23:0];
  assign cur_v = $signed(rdata[39:24]);

  apsu_ram #(.WIDTH(40), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (wr && !full),
    .waddr (count[AW-1:0]),
    .wdata ({wr_value, wr_time}),
    .raddr (issue[AW-1:0]),
    .rdata (rdata)
  );

  // result comes straight from a breakpoint, no interpolation needed
  assign early = (count == CW'(1)) || (t_q <= first_t) || (t_q >= last_t) || (s_t1 <= s_t0);

  always_comb begin
    prod    = $signed({18'd0, dt}) * dv;
    mag     = prod[41] ? 42'(-prod) : prod;
    sh      = {rem, quo[QW-1]};
    qbit    = (sh >= {1'b0, den});
    qs      = $signed({1'b0, quo});
    fin_sum = {{2{s_v0[15]}}, s_v0} + (neg ? -qs : qs);
  end

  always_comb begin
    state_next = state;
    case (state)
      apsu_pkg::ENV_IDLE: begin
        if (start) begin
          state_next = (count == '0) ? apsu_pkg::ENV_DONE : apsu_pkg::ENV_SCAN;
        end
      end
      apsu_pkg::ENV_SCAN: begin
        if (rd_valid && (rd_pos == CW'(count - 1'b1))) begin
          state_next = apsu_pkg::ENV_EVAL;
        end
      end
      apsu_pkg::ENV_EVAL: state_next = early ? apsu_pkg::ENV_DONE : apsu_pkg::ENV_MUL;
      apsu_pkg::ENV_MUL:  state_next = apsu_pkg::ENV_DIV;
      apsu_pkg::ENV_DIV: begin
        if (qstep == apsu_pkg::QSTEP_W'(QW - 1)) begin
          state_next = apsu_pkg::ENV_FIN;
        end
      end
      apsu_pkg::ENV_FIN:  state_next = apsu_pkg::ENV_DONE;
      apsu_pkg::ENV_DONE: state_next = apsu_pkg::ENV_IDLE;
      default:            state_next = apsu_pkg::ENV_IDLE;
    endcase
  end

  always_comb begin
    done = (state == apsu_pkg::ENV_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= apsu_pkg::ENV_IDLE;
      count    <= '0;
      issue    <= '0;
      rd_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clear) begin
        count <= '0;
      end else if (wr && !full) begin
        count <= count + 1'b1;
      end
      if (state == apsu_pkg::ENV_IDLE) begin
        issue <= '0;
      end else if ((state == apsu_pkg::ENV_SCAN) && (issue < count)) begin
        issue <= issue + 1'b1;
      end
      rd_valid <= (state == apsu_pkg::ENV_SCAN) && (issue < count);
    end
  end

  always_ff @(posedge clk) begin
    rd_pos <= issue;
    case (state)
      apsu_pkg::ENV_IDLE: begin
        t_q <= t;
        if (start && (count == '0)) begin
          value <= apsu_pkg::ONE_Q12;
        end
      end
      apsu_pkg::ENV_SCAN: begin
        if (rd_valid) begin
          if (rd_pos == '0) begin
            first_t <= cur_t;
            first_v <= cur_v;
            found   <= 1'b0;
          end else if (!found && (cur_t > t_q)) begin
            s_t0  <= prev_t;
            s_v0  <= prev_v;
            s_t1  <= cur_t;
            s_v1  <= cur_v;
            found <= 1'b1;
          end
          prev_t <= cur_t;
          prev_v <= cur_v;
          last_t <= cur_t;
          last_v <= cur_v;
        end
      end
      apsu_pkg::ENV_EVAL: begin
        if ((count == CW'(1)) || (t_q <= first_t)) begin
          value <= first_v;
        end else if (t_q >= last_t) begin
          value <= last_v;
        end else begin
          value <= s_v0;
        end
        dt  <= t_q - s_t0;
        dv  <= {s_v1[15], s_v1} - {s_v0[15], s_v0};
        den <= s_t1 - s_t0;
      end
      apsu_pkg::ENV_MUL: begin
        neg   <= prod[41];
        rem   <= mag[40:QW];
        quo   <= mag[QW-1:0];
        qstep <= '0;
      end
      apsu_pkg::ENV_DIV: begin
        rem   <= qbit ? 24'(sh - {1'b0, den}) : sh[23:0];
        quo   <= {quo[QW-2:0], qbit};
        qstep <= qstep + 1'b1;
      end
      apsu_pkg::ENV_FIN: begin
        value <= fin_sum[15:0];
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/apsu_osc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsu_osc
// partial store, phase accumulators and the pipelined oscillator sum
// ----------------------------------------------------------------------------
module apsu_osc #(
  parameter int MAX_PARTIALS    = apsu_pkg::MAX_PARTIALS_DEF,
  parameter int SINE_INDEX_BITS = apsu_pkg::SINE_INDEX_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               add,
  input  logic [31:0]        add_inc,
  input  logic signed [15:0] add_gain,
  input  logic [15:0]        add_ofs,
  input  logic [23:0]        t,
  output logic               full,
  input  logic               run,
  input  logic               restart,
  input  logic signed [15:0] ph_env,
  output logic               done,
  output logic signed [apsu_pkg::sum_width(MAX_PARTIALS)-1:0] sum
);

  localparam int SUM_W   = apsu_pkg::sum_width(MAX_PARTIALS);
  localparam int CW      = $clog2(MAX_PARTIALS + 1);
  localparam int AW      = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
  localparam int SIB     = SINE_INDEX_BITS;
  localparam int QUARTER = 1 << (SIB - 2);

  apsu_pkg::osc_state_t state, state_next;

  logic [CW-1:0]        count, issue;
  logic [31:0]          inc_q, acc_init;
  logic signed [15:0]   gain_q;
  logic [15:0]          ofs_q;
  logic [23:0]          t_q;
  logic                 restart_q;
  logic [63:0]          part_rd;
  logic [31:0]          acc_rd;
  logic [31:0]          acc_base, angle;
  logic                 v1, v2, v3, v4;
  logic [CW-1:0]        pos1;
  logic [SIB-1:0]       idx2;
  logic signed [15:0]   gain2, gain3, sine3;
  logic signed [31:0]   prod4;
  logic [SIB-2:0]       qaddr;
  logic signed [15:0]   qsine;
  logic [14:0]          rom [QUARTER+1];
  logic                 issuing;

  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    assign rom[k] = apsu_pkg::quarter_sine(k, SIB);
  end

  assign full    = (count == CW'(MAX_PARTIALS));
  assign issuing = (state == apsu_pkg::OSC_RUN) && (issue < count);

  // partial entry: step low, gain, offset high
  apsu_ram #(.WIDTH(64), .DEPTH(MAX_PARTIALS)) u_part (
    .clk   (clk),
    .we    (state == apsu_pkg::OSC_WRITE),
    .waddr (count[AW-1:0]),
    .wdata ({ofs_q, gain_q, inc_q}),
    .raddr (issue[AW-1:0]),
    .rdata (part_rd)
  );

  apsu_ram #(.WIDTH(32), .DEPTH(MAX_PARTIALS)) u_acc (
    .clk   (clk),
    .we    (v1 || (state == apsu_pkg::OSC_WRITE)),
    .waddr (v1 ? pos1[AW-1:0] : count[AW-1:0]),
    .wdata (v1 ? (acc_base + part_rd[31:0]) : acc_init),
    .raddr (issue[AW-1:0]),
    .rdata (acc_rd)
  );

  always_comb begin
    acc_base = restart_q ? 32'd0 : acc_rd;
    angle    = acc_base + {part_rd[63:48], 16'd0} + {ph_env[11:0], 20'd0};
    qaddr    = idx2[SIB-2] ? ((SIB-1)'(QUARTER) - {1'b0, idx2[SIB-3:0]})
                           : {1'b0, idx2[SIB-3:0]};
    qsine    = $signed({1'b0, rom[qaddr]});
  end

  always_comb begin
    state_next = state;
    case (state)
      apsu_pkg::OSC_IDLE: begin
        if (add && !full) begin
          state_next = apsu_pkg::OSC_ADD;
        end else if (run) begin
          state_next = apsu_pkg::OSC_RUN;
        end
      end
      apsu_pkg::OSC_ADD:   state_next = apsu_pkg::OSC_WRITE;
      apsu_pkg::OSC_WRITE: state_next = apsu_pkg::OSC_DONE;
      apsu_pkg::OSC_RUN: begin
        if (!issuing && !v1 && !v2 && !v3 && !v4) begin
          state_next = apsu_pkg::OSC_DONE;
        end
      end
      apsu_pkg::OSC_DONE:  state_next = apsu_pkg::OSC_IDLE;
      default:             state_next = apsu_pkg::OSC_IDLE;
    endcase
  end

  always_comb begin
    done = (state == apsu_pkg::OSC_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apsu_pkg::OSC_IDLE;
      count <= '0;
      issue <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
    end else begin
      state <= state_next;
      if (clear) begin
        count <= '0;
      end else if (state == apsu_pkg::OSC_WRITE) begin
        count <= count + 1'b1;
      end
      if (state == apsu_pkg::OSC_IDLE) begin
        issue <= '0;
      end else if (issuing) begin
        issue <= issue + 1'b1;
      end
      v1 <= issuing;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (state == apsu_pkg::OSC_IDLE) begin
      inc_q     <= add_inc;
      gain_q    <= add_gain;
      ofs_q     <= add_ofs;
      t_q       <= t;
      restart_q <= restart;
      sum       <= '0;
    end
    // new accumulator lines up with partials loaded earlier
    acc_init <= 32'(inc_q * t_q);
    pos1     <= issue;
    idx2     <= angle[31 -: SIB];
    gain2    <= $signed(part_rd[47:32]);
    gain3    <= gain2;
    sine3    <= idx2[SIB-1] ? -qsine : qsine;
    prod4    <= gain3 * sine3;
    if (v4) begin
      sum <= sum + SUM_W'(prod4);
    end
  end

endmodule

// File: design/additive_partial_synth_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// additive_partial_synth_unit
// additive oscillator bank with amplitude and phase envelopes
// ----------------------------------------------------------------------------
// usage
// - s_* carries one command item: s_tuser holds the command and the restart
//   flag, s_tdata holds the partial and breakpoint fields
// - every accepted item gives exactly one result item on m_*; only a sample
//   command sets sample_valid, a full table sets status and drops the entry
// - clear and load commands go from acceptance straight to the output state,
//   an added partial after the add and write steps (its starting phase needs a
//   multiply)
// - a sample command scans both breakpoint memories, interpolates with a
//   restoring divider (skipped where no interpolation is needed), runs the
//   partials through a 5-stage pipeline (one partial memory read per cycle)
//   and scales in the low product, high product, scale and saturate steps
// - one item is in work at a time; s_tready is high only while idle
// - a result waits in the output register while m_tready is low, the next
//   item is taken once it has been loaded there
// - reset empties all tables and zeroes the sample counter; no clearing pass
//   is needed since only entries below the counts are ever read
// ----------------------------------------------------------------------------
module additive_partial_synth_unit #(
  parameter int MAX_PARTIALS    = apsu_pkg::MAX_PARTIALS_DEF,
  parameter int MAX_POINTS      = apsu_pkg::MAX_POINTS_DEF,
  parameter int SINE_INDEX_BITS = apsu_pkg::SINE_INDEX_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // partial_increment, partial_amplitude, partial_phase, point_time,
  // point_value
  input  logic [103:0] s_tdata,
  // cmd, restart
  input  logic [3:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // sample, sample_index
  output logic [55:0]  m_tdata,
  // sample_valid, status
  output logic [1:0]   m_tuser
);

  localparam int SUM_W = apsu_pkg::sum_width(MAX_PARTIALS);
  localparam int HI_W  = SUM_W - 20;
  localparam int SC_W  = SUM_W + 16;

  apsu_pkg::top_state_t state, state_next;

  // input item fields
  logic [2:0]         in_cmd;
  logic               in_restart;
  logic [31:0]        in_inc;
  logic signed [15:0] in_gain;
  logic [15:0]        in_ofs;
  logic [23:0]        in_time;
  logic signed [15:0] in_value;

  logic               accept;
  logic [23:0]        counter;
  logic [23:0]        t_now;

  // control between this level and the units
  logic osc_add, osc_run, osc_full, osc_done;
  logic amp_wr, amp_full, amp_done, ph_wr, ph_full, ph_done;
  logic env_start, clear;
  logic amp_ok, ph_ok;
  logic signed [15:0] amp_val, ph_val;
  logic signed [15:0] amp_env_q, ph_env_q;
  logic signed [SUM_W-1:0] osc_sum, sum_q;
  logic restart_q;

  // scaling and result
  logic signed [36:0]     p_lo;
  logic signed [HI_W+15:0] p_hi;
  logic signed [SC_W-1:0] scaled;
  logic signed [63:0]     res64;
  logic [31:0]            res_sample;
  logic [23:0]            res_index;
  logic                   res_valid, res_status;
  logic                   full_hit;

  assign in_cmd     = s_tuser[2:0];
  assign in_restart = s_tuser[3];
  assign in_inc     = s_tdata[31:0];
  assign in_gain    = $signed(s_tdata[47:32]);
  assign in_ofs     = s_tdata[63:48];
  assign in_time    = s_tdata[87:64];
  assign in_value   = $signed(s_tdata[103:88]);

  assign s_tready = (state == apsu_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign t_now    = in_restart ? 24'd0 : counter;

  apsu_osc #(
    .MAX_PARTIALS    (MAX_PARTIALS),
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_osc (
    .clk      (clk),
    .rst      (rst),
    .clear    (clear),
    .add      (osc_add),
    .add_inc  (in_inc),
    .add_gain (in_gain),
    .add_ofs  (in_ofs),
    .t        (counter),
    .full     (osc_full),
    .run      (osc_run),
    .restart  (restart_q),
    .ph_env   (ph_env_q),
    .done     (osc_done),
    .sum      (osc_sum)
  );

  apsu_env #(.MAX_POINTS(MAX_POINTS)) u_amp_env (
    .clk      (clk),
    .rst      (rst),
    .clear    (clear),
    .wr       (amp_wr),
    .wr_time  (in_time),
    .wr_value (in_value),
    .full     (amp_full),
    .start    (env_start),
    .t        (t_now),
    .done     (amp_done),
    .value    (amp_val)
  );

  apsu_env #(.MAX_POINTS(MAX_POINTS)) u_ph_env (
    .clk      (clk),
    .rst      (rst),
    .clear    (clear),
    .wr       (ph_wr),
    .wr_time  (in_time),
    .wr_value (in_value),
    .full     (ph_full),
    .start    (env_start),
    .t        (t_now),
    .done     (ph_done),
    .value    (ph_val)
  );

  // table full check for the load commands
  always_comb begin
    case (in_cmd)
      apsu_pkg::CMD_PARTIAL: full_hit = osc_full;
      apsu_pkg::CMD_AMP:     full_hit = amp_full;
      apsu_pkg::CMD_PHASE:   full_hit = ph_full;
      default:               full_hit = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      apsu_pkg::ST_IDLE: begin
        if (accept) begin
          if ((in_cmd == apsu_pkg::CMD_PARTIAL) && !osc_full) begin
            state_next = apsu_pkg::ST_ADD;
          end else if (in_cmd == apsu_pkg::CMD_SAMPLE) begin
            state_next = apsu_pkg::ST_ENV;
          end else begin
            state_next = apsu_pkg::ST_OUT;
          end
        end
      end
      apsu_pkg::ST_ADD: begin
        if (osc_done) begin
          state_next = apsu_pkg::ST_OUT;
        end
      end
      apsu_pkg::ST_ENV: begin
        if ((amp_ok || amp_done) && (ph_ok || ph_done)) begin
          state_next = apsu_pkg::ST_OSC;
        end
      end
      apsu_pkg::ST_OSC: begin
        if (osc_done) begin
          state_next = apsu_pkg::ST_MLO;
        end
      end
      apsu_pkg::ST_MLO:   state_next = apsu_pkg::ST_MHI;
      apsu_pkg::ST_MHI:   state_next = apsu_pkg::ST_SCALE;
      apsu_pkg::ST_SCALE: state_next = apsu_pkg::ST_SAT;
      apsu_pkg::ST_SAT:   state_next = apsu_pkg::ST_OUT;
      apsu_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = apsu_pkg::ST_IDLE;
        end
      end
      default: state_next = apsu_pkg::ST_IDLE;
    endcase
  end

  // unit strobes
  always_comb begin
    clear     = accept && (in_cmd == apsu_pkg::CMD_CLEAR);
    osc_add   = accept && (in_cmd == apsu_pkg::CMD_PARTIAL);
    amp_wr    = accept && (in_cmd == apsu_pkg::CMD_AMP);
    ph_wr     = accept && (in_cmd == apsu_pkg::CMD_PHASE);
    env_start = accept && (in_cmd == apsu_pkg::CMD_SAMPLE);
    osc_run   = (state == apsu_pkg::ST_ENV) && (amp_ok || amp_done) && (ph_ok || ph_done);
  end

  always_comb begin
    res64 = 64'(scaled) >>> 23;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= apsu_pkg::ST_IDLE;
      counter  <= '0;
      m_tvalid <= 1'b0;
      amp_ok   <= 1'b0;
      ph_ok    <= 1'b0;
    end else begin
      state <= state_next;
      if (env_start && in_restart) begin
        counter <= '0;
      end else if (state == apsu_pkg::ST_SAT) begin
        counter <= counter + 1'b1;
      end
      if (state == apsu_pkg::ST_IDLE) begin
        amp_ok <= 1'b0;
        ph_ok  <= 1'b0;
      end else begin
        amp_ok <= amp_ok || amp_done;
        ph_ok  <= ph_ok || ph_done;
      end
      if ((state == apsu_pkg::ST_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    if (accept) begin
      restart_q  <= in_restart;
      res_sample <= '0;
      res_index  <= '0;
      res_valid  <= (in_cmd == apsu_pkg::CMD_SAMPLE);
      res_status <= full_hit;
    end
    if (amp_done) begin
      amp_env_q <= amp_val;
    end
    if (ph_done) begin
      ph_env_q <= ph_val;
    end
    if (osc_done) begin
      sum_q <= osc_sum;
    end
    // sum times amplitude envelope, cut into two partial products
    if (state == apsu_pkg::ST_MLO) begin
      p_lo <= $signed({1'b0, sum_q[19:0]}) * amp_env_q;
    end
    if (state == apsu_pkg::ST_MHI) begin
      p_hi <= $signed(sum_q[SUM_W-1:20]) * amp_env_q;
    end
    if (state == apsu_pkg::ST_SCALE) begin
      scaled <= (SC_W'(p_hi) <<< 20) + SC_W'(p_lo);
    end
    if (state == apsu_pkg::ST_SAT) begin
      res_index <= counter;
      if (res64 > 64'sd2147483647) begin
        res_sample <= 32'h7FFF_FFFF;
      end else if (res64 < -64'sd2147483648) begin
        res_sample <= 32'h8000_0000;
      end else begin
        res_sample <= res64[31:0];
      end
    end
    if ((state == apsu_pkg::ST_OUT) && (!m_tvalid || m_tready)) begin
      m_tdata <= {res_index, res_sample};
      m_tuser <= {res_status, res_valid};
    end
  end

endmodule

// File: bench/additive_partial_synth_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// additive_partial_synth_unit_tb
// self-checking bench for the additive oscillator bank
// ----------------------------------------------------------------------------
// a short table of directed commands (empty tables, unknown commands,
// extreme fields, envelope edges) is followed by random load-and-play
// sequences with some noise; every result item is checked field by field against the
// typed result of its table row where one is given, else a behavioral oscillator bank kept inside the bench
// ----------------------------------------------------------------------------
module additive_partial_synth_unit_tb;

  localparam int NPART     = apsu_pkg::MAX_PARTIALS_DEF;
  localparam int NPTS      = apsu_pkg::MAX_POINTS_DEF;
  localparam int IDX_BITS  = apsu_pkg::SINE_INDEX_BITS_DEF;
  localparam int ROM_N     = 1 << IDX_BITS;
  localparam int RAND_ITEMS = 1600;
  localparam int CYCLE_LIMIT = 1000000;

  // one command item as the bench sees it
  typedef struct {
    logic [2:0]         cmd;
    logic               restart;
    logic [31:0]        incr;
    logic signed [15:0] gain;
    logic [15:0]        ofs;
    logic [23:0]        ptime;
    logic signed [15:0] pval;
  } synth_cmd_t;

  // one result item
  typedef struct {
    logic [31:0] sample;
    logic        valid;
    logic [23:0] index;
    logic        status;
  } synth_out_t;

  // directed row: typed result only where chk is set
  typedef struct {
    synth_cmd_t c;
    bit         chk;
    synth_out_t r;
  } dir_row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [103:0] s_tdata;
  logic [3:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [55:0]  m_tdata;
  logic [1:0]   m_tuser;

  additive_partial_synth_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // model state of the oscillator bank
  int                 sine_lut[ROM_N];
  logic [31:0]        osc_step[NPART];
  logic signed [15:0] osc_gain[NPART];
  logic [15:0]        osc_ofs[NPART];
  logic [31:0]        osc_phase[NPART];
  int                 n_osc;
  logic [23:0]        amp_t[NPTS];
  logic signed [15:0] amp_v[NPTS];
  int                 n_amp;
  logic [23:0]        phs_t[NPTS];
  logic signed [15:0] phs_v[NPTS];
  int                 n_phs;
  logic [23:0]        sample_time;

  synth_out_t pending_results[$];
  int         errors;
  int         cycles;
  bit         quiet;     // no idling on either side while set
  int         sent;

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[additive_partial_synth_unit] ERROR");
      $finish;
    end
  end

  // ----------------------------------------------------------- sine table
  // quarter wave from a truncating q30 taylor series to x^13
  function automatic int quarter_wave(input int unsigned q);
    longint unsigned x, term;
    longint          s;
    x    = (64'(q) * apsu_pkg::TWO_PI_Q30) >> IDX_BITS;
    term = x;
    s    = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    s = (s + 16384) >>> 15;
    if (s > 32767) s = 32767;
    return int'(s);
  endfunction

  initial begin
    int quad, r, v;
    for (int k = 0; k < ROM_N; k++) begin
      quad = k / (ROM_N / 4);
      r    = k % (ROM_N / 4);
      v    = (quad % 2 == 1) ? quarter_wave(ROM_N / 4 - r) : quarter_wave(r);
      sine_lut[k] = (quad >= 2) ? -v : v;
    end
  end

  // ------------------------------------------------------------ predictor
  // breakpoint interpolation with a divide truncated toward zero
  function automatic int interp_env(input logic [23:0] tt[NPTS],
                                    input logic signed [15:0] vv[NPTS],
                                    input int n, input logic [23:0] t);
    int     seg;
    longint t0, t1, v0, v1;
    if (n == 0) return 4096;
    if (n == 1 || t <= tt[0]) return vv[0];
    if (t >= tt[n-1]) return vv[n-1];
    seg = n - 2;
    for (int i = 0; i + 1 < n; i++) begin
      if (tt[i+1] > t) begin
        seg = i;
        break;
      end
    end
    t0 = tt[seg];
    t1 = tt[seg+1];
    v0 = vv[seg];
    v1 = vv[seg+1];
    if (t1 <= t0) return int'(v0);
    return int'(v0 + (longint'(t) - t0) * (v1 - v0) / (t1 - t0));
  endfunction

  // applies one command to the model bank and returns its result item
  function automatic synth_out_t synth_step(input synth_cmd_t c);
    synth_out_t  o;
    int          amp_env, ph_env;
    logic [31:0] ang, ph_turns;
    longint      acc, res;
    o = '{default: '0};
    case (c.cmd)
      apsu_pkg::CMD_CLEAR: begin
        n_osc = 0;
        n_amp = 0;
        n_phs = 0;
      end
      apsu_pkg::CMD_PARTIAL: begin
        if (n_osc < NPART) begin
          osc_step[n_osc]  = c.incr;
          osc_gain[n_osc]  = c.gain;
          osc_ofs[n_osc]   = c.ofs;
          osc_phase[n_osc] = 32'(64'(c.incr) * 64'(sample_time));
          n_osc++;
        end else o.status = 1'b1;
      end
      apsu_pkg::CMD_AMP: begin
        if (n_amp < NPTS) begin
          amp_t[n_amp] = c.ptime;
          amp_v[n_amp] = c.pval;
          n_amp++;
        end else o.status = 1'b1;
      end
      apsu_pkg::CMD_PHASE: begin
        if (n_phs < NPTS) begin
          phs_t[n_phs] = c.ptime;
          phs_v[n_phs] = c.pval;
          n_phs++;
        end else o.status = 1'b1;
      end
      apsu_pkg::CMD_SAMPLE: begin
        if (c.restart) begin
          sample_time = '0;
          for (int i = 0; i < NPART; i++) osc_phase[i] = '0;
        end
        amp_env  = interp_env(amp_t, amp_v, n_amp, sample_time);
        ph_env   = interp_env(phs_t, phs_v, n_phs, sample_time);
        ph_turns = 32'(ph_env) << 20;
        acc = 0;
        for (int i = 0; i < n_osc; i++) begin
          ang = osc_phase[i] + (32'(osc_ofs[i]) << 16) + ph_turns;
          acc += longint'(osc_gain[i]) * sine_lut[ang >> (32 - IDX_BITS)];
        end
        // arithmetic shift gives the floor of the scaled sum
        res = (acc * amp_env) >>> 23;
        if (res > 64'sh7fffffff) res = 64'sh7fffffff;
        if (res < -64'sh80000000) res = -64'sh80000000;
        o.sample = res[31:0];
        o.valid  = 1'b1;
        o.index  = sample_time;
        for (int i = 0; i < n_osc; i++) osc_phase[i] += osc_step[i];
        sample_time = sample_time + 24'd1;
      end
      default: ;  // unknown commands leave everything alone
    endcase
    return o;
  endfunction

  // --------------------------------------------------------------- driver
  // one item: optional idle gap, then hold until the handshake completes
  task automatic drive_cmd(input synth_cmd_t c, input bit typed,
                           input synth_out_t want);
    synth_out_t got;
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 6) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {c.pval, c.ptime, c.ofs, c.gain, c.incr};
    s_tuser  = {c.restart, c.cmd};
    do @(posedge clk); while (!s_tready);
    got = synth_step(c);
    pending_results.push_back(typed ? want : got);
    sent++;
  endtask

  function automatic synth_cmd_t rand_cmd(input logic [2:0] op);
    synth_cmd_t c;
    c.cmd     = op;
    c.restart = 1'($urandom);
    c.incr    = $urandom;
    c.gain    = 16'($urandom);
    c.ofs     = 16'($urandom);
    c.ptime   = 24'($urandom);
    c.pval    = 16'($urandom);
    return c;
  endfunction

  // well-formed program: clear, load partials and sorted breakpoints, play
  task automatic play_program();
    synth_cmd_t c;
    synth_out_t none;
    int         np, na, nph, ns;
    logic [23:0] t;
    none = '{default: '0};
    drive_cmd(rand_cmd(apsu_pkg::CMD_CLEAR), 0, none);
    np  = ($urandom_range(9) == 0) ? $urandom_range(NPART, NPART + 3)
                                   : $urandom_range(1, 6);
    na  = ($urandom_range(9) == 0) ? $urandom_range(NPTS, NPTS + 2)
                                   : $urandom_range(0, 4);
    nph = ($urandom_range(9) == 0) ? $urandom_range(NPTS, NPTS + 2)
                                   : $urandom_range(0, 3);
    for (int i = 0; i < np; i++) begin
      c = rand_cmd(apsu_pkg::CMD_PARTIAL);
      // small gains keep most sums clear of saturation
      if ($urandom_range(3) != 0) c.gain = 16'($signed($urandom_range(0, 4096)) - 2048);
      drive_cmd(c, 0, none);
    end
    t = 24'($urandom_range(0, 6));
    for (int i = 0; i < na; i++) begin
      c = rand_cmd(apsu_pkg::CMD_AMP);
      c.ptime = t;
      if ($urandom_range(3) != 0) c.pval = 16'($urandom_range(0, 8192));
      t = t + 24'($urandom_range(0, 12));
      drive_cmd(c, 0, none);
    end
    t = 24'($urandom_range(0, 6));
    for (int i = 0; i < nph; i++) begin
      c = rand_cmd(apsu_pkg::CMD_PHASE);
      c.ptime = t;
      t = t + 24'($urandom_range(0, 15));
      drive_cmd(c, 0, none);
    end
    ns = $urandom_range(8, 40);
    for (int i = 0; i < ns; i++) begin
      c = rand_cmd(apsu_pkg::CMD_SAMPLE);
      c.restart = (i == 0) ? 1'b1 : ($urandom_range(30) == 0);
      drive_cmd(c, 0, none);
    end
  endtask

  // ------------------------------------------------------- result checker
  always @(posedge clk) begin
    synth_out_t act, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      act.sample = m_tdata[31:0];
      act.index  = m_tdata[55:32];
      act.valid  = m_tuser[0];
      act.status = m_tuser[1];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item sample=%h", $time, act.sample);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (act.sample !== exp_r.sample) begin
          $display("%0t: sample exp %h got %h", $time, exp_r.sample, act.sample);
          errors++;
        end
        if (act.valid !== exp_r.valid) begin
          $display("%0t: sample_valid exp %b got %b", $time, exp_r.valid, act.valid);
          errors++;
        end
        if (act.index !== exp_r.index) begin
          $display("%0t: sample_index exp %h got %h", $time, exp_r.index, act.index);
          errors++;
        end
        if (act.status !== exp_r.status) begin
          $display("%0t: status exp %b got %b", $time, exp_r.status, act.status);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, none while quiet
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      m_tready = quiet ? 1'b1 : ($urandom_range(99) >= 6);
    end
  end

  // ------------------------------------------------------------- stimulus
  initial begin
    dir_row_t   rows[$];
    synth_cmd_t z;
    synth_out_t none;
    bit         drained;
    sent    = 0;
    quiet   = 1'b0;
    drained = 1'b0;
    n_osc = 0; n_amp = 0; n_phs = 0;
    sample_time = '0;
    for (int i = 0; i < NPART; i++) osc_phase[i] = '0;
    z    = '{cmd: apsu_pkg::CMD_CLEAR, restart: 1'b0, incr: '0, gain: '0, ofs: '0,
             ptime: '0, pval: '0};
    none = '{default: '0};

    // empty tables right after reset: a silent sample at time zero
    rows.push_back('{'{apsu_pkg::CMD_SAMPLE, 1'b0, '0, '0, '0, '0, '0}, 1,
                     '{32'h0, 1'b1, 24'h0, 1'b0}});
    // unknown commands give an all-zero item
    rows.push_back('{'{3'd5, 1'b0, '0, '0, '0, '0, '0}, 1, none});
    rows.push_back('{'{3'd7, 1'b1, '1, '1, '1, '1, '1}, 1, none});
    rows.push_back('{'{3'd6, 1'b1, '1, '1, '1, '1, '1}, 1, none});
    rows.push_back('{z, 1, none});
    // second sample still with empty tables: time one
    rows.push_back('{'{apsu_pkg::CMD_SAMPLE, 1'b0, '1, '1, '1, '1, '1}, 1,
                     '{32'h0, 1'b1, 24'h1, 1'b0}});
    // partials at the field extremes, loaded mid-run
    rows.push_back('{'{apsu_pkg::CMD_PARTIAL, 1'b0, 32'h0, 16'sh7fff, 16'h4000, '0, '0},
                     0, none});
    rows.push_back('{'{apsu_pkg::CMD_PARTIAL, 1'b1, 32'hffffffff, -16'sh8000, 16'hffff,
                       '1, '1}, 0, none});
    rows.push_back('{'{apsu_pkg::CMD_PARTIAL, 1'b0, 32'h8000_0000, 16'sh1000, 16'h0, '0, '0},
                     0, none});
    rows.push_back('{'{apsu_pkg::CMD_SAMPLE, 1'b0, '0, '0, '0, '0, '0}, 0, none});
    // amplitude envelope from full scale down to most negative
    rows.push_back('{'{apsu_pkg::CMD_AMP, 1'b0, '0, '0, '0, 24'd0, 16'sh7fff}, 0, none});
    rows.push_back('{'{apsu_pkg::CMD_AMP, 1'b0, '0, '0, '0, 24'd10, -16'sh8000}, 0, none});
    // phase envelope across the whole time range
    rows.push_back('{'{apsu_pkg::CMD_PHASE, 1'b0, '0, '0, '0, 24'd0, -16'sh8000}, 0, none});
    rows.push_back('{'{apsu_pkg::CMD_PHASE, 1'b0, '0, '0, '0, 24'hffffff, 16'sh7fff},
                     0, none});
    rows.push_back('{'{apsu_pkg::CMD_SAMPLE, 1'b1, '0, '0, '0, '0, '0}, 0, none});
    rows.push_back('{'{apsu_pkg::CMD_SAMPLE, 1'b0, '0, '0, '0, '0, '0}, 0, none});
    rows.push_back('{'{apsu_pkg::CMD_SAMPLE, 1'b0, '0, '0, '0, '0, '0}, 0, none});
    // unsorted breakpoint goes in as it stands
    rows.push_back('{'{apsu_pkg::CMD_AMP, 1'b0, '0, '0, '0, 24'd4, 16'sh0800}, 0, none});
    rows.push_back('{'{apsu_pkg::CMD_SAMPLE, 1'b0, '0, '0, '0, '0, '0}, 0, none});
    rows.push_back('{'{apsu_pkg::CMD_SAMPLE, 1'b0, '0, '0, '0, '0, '0}, 0, none});
    rows.push_back('{'{apsu_pkg::CMD_SAMPLE, 1'b0, '0, '0, '0, '0, '0}, 0, none});
    // clear keeps the sample counter running
    rows.push_back('{z, 1, none});
    rows.push_back('{'{apsu_pkg::CMD_SAMPLE, 1'b0, '0, '0, '0, '0, '0}, 1,
                     '{32'h0, 1'b1, 24'd6, 1'b0}});

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) drive_cmd(rows[i].c, rows[i].chk, rows[i].r);

    sent = 0;
    while (sent < RAND_ITEMS) begin
      // a stretch with no idling on either side
      quiet = (sent >= 600 && sent < 900);
      // once, let everything drain before going on
      if (!drained && sent >= 1000) begin
        drained = 1'b1;
        @(negedge clk);
        s_tvalid = 1'b0;
        wait (pending_results.size() == 0);
      end
      if ($urandom_range(4) == 0)
        drive_cmd(rand_cmd(3'($urandom_range(7))), 0, none);
      else
        play_program();
    end
    quiet = 1'b0;
    @(negedge clk);
    s_tvalid = 1'b0;

    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("[additive_partial_synth_unit] OK");
    end else begin
      $display("[additive_partial_synth_unit] ERROR");
    end
    $finish;
  end

endmodule
